@@ hw/rtl/rnd_pkg.sv @@
`default_nettype none
package rnd_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;

    // worst case digit count is radix 2
    localparam int DIGITS      = VALUE_WIDTH;
    localparam int CONV_CYCLES = VALUE_WIDTH + DIGITS - 1;
    localparam int CNT_W       = $clog2(CONV_CYCLES);
    localparam int REM_W       = $clog2(DIGITS + 1);

    localparam int S_TDATA_W   = ((VALUE_WIDTH + BASE_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((CHAR_W + 7) / 8) * 8;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd65;  // 'A'
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic clr;
        logic conv_en;
        logic shift_en;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_TEN) begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end else begin
            ch = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rnd_cell.sv @@
`default_nettype none
// One radix-b digit: doubles itself plus the carry from below each step.
module rnd_cell
    import rnd_pkg::*;
(
    input  wire logic               aclk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [BASE_W-1:0]  base,
    input  wire logic               carry_in,
    input  wire logic [DIGIT_W-1:0] shift_in,
    output logic [DIGIT_W-1:0]      digit,
    output logic                    carry_out
);

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               carry_reg, carry_next;
    logic [BASE_W-1:0]  twice;
    logic [BASE_W-1:0]  diff;
    logic               ge;

    // 2*d + c, d < base so result < 2*base
    assign twice = {digit_reg, carry_in};
    assign ge    = (twice >= base);
    assign diff  = twice - base;

    always_comb begin
        digit_next = digit_reg;
        carry_next = carry_reg;
        if (ctrl.clr) begin
            digit_next = '0;
            carry_next = 1'b0;
        end else if (ctrl.conv_en) begin
            digit_next = ge ? diff[DIGIT_W-1:0] : twice[DIGIT_W-1:0];
            carry_next = ge;
        end else if (ctrl.shift_en) begin
            digit_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
        carry_reg <= carry_next;
    end

    assign digit     = digit_reg;
    assign carry_out = carry_reg;

endmodule
`default_nettype wire

@@ hw/rtl/rnd_out_reg.sv @@
`default_nettype none
// Output holding register for the digit stream.
module rnd_out_reg
    import rnd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic [CHAR_W-1:0] char_in,
    input  wire logic              last_in,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast
);

    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= char_in;
            last_reg <= last_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'(char_reg);
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

@@ hw/rtl/radix_n_digit_converter.sv @@
`default_nettype none
// Channel  | dir | tdata (low bit up)                  | tlast
// ---------+-----+-------------------------------------+-------------------
// s_       | in  | value[30:0], base[35:31], pad to 40 | -
// m_       | out | digit_char[6:0], pad to 8           | last digit of item
//
// One item at a time: after the accept beat the value shifts in MSB first
// through radix-b digit cells with registered carries until the row settles.
// Then one digit shifts out per cycle while the output register can take it,
// top first; leading zeros drop without a beat. m_tready low stretches
// the emit phase only; the next item waits until the last digit is in the
// output register. Reset clears the control state and output valid.
module radix_n_digit_converter
    import rnd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value, base
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // digit_char
    output logic                      m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic                   lead_reg, lead_next;
    logic [VALUE_WIDTH-1:0] val_sr_reg, val_sr_next;
    logic [BASE_W-1:0]      base_reg, base_next;

    logic                   in_beat;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [BASE_W-1:0]      in_base;
    logic                   can_load;
    logic                   emit;
    logic                   skip;
    logic                   shift;
    logic                   rem_one;
    logic [DIGIT_W-1:0]     top_digit;

    logic [DIGIT_W-1:0]     digit_w [DIGITS];
    logic                   carry_w [DIGITS];

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_base  = s_tdata[VALUE_WIDTH +: BASE_W];

    assign top_digit = digit_w[DIGITS-1];
    assign rem_one   = (rem_reg == REM_W'(1));

    // leading zero: drop it unless it is the only digit left
    assign skip  = (state_reg == S_EMIT) && lead_reg && (top_digit == '0) && !rem_one;
    assign emit  = (state_reg == S_EMIT) && !skip && can_load;
    assign shift = skip || emit;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        lead_next   = lead_reg;
        val_sr_next = val_sr_reg;
        base_next   = base_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    val_sr_next = in_value;
                    if (in_base < BASE_MIN) begin
                        base_next = BASE_MIN;
                    end else if (in_base > BASE_MAX) begin
                        base_next = BASE_MAX;
                    end else begin
                        base_next = in_base;
                    end
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV: begin
                val_sr_next = {val_sr_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CONV_CYCLES - 1)) begin
                    rem_next   = REM_W'(DIGITS);
                    lead_next  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (shift) begin
                    rem_next = rem_reg - REM_W'(1);
                end
                if (emit) begin
                    lead_next = 1'b0;
                    if (rem_one) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            lead_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            lead_reg  <= lead_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_sr_reg <= val_sr_next;
        base_reg   <= base_next;
    end

    // digit row: cell i takes step k at counter value k+i, so it stops after
    // counter value i + VALUE_WIDTH - 1
    for (genvar gi = 0; gi < DIGITS; gi++) begin : g_cell
        cell_ctrl_t         ctrl;
        logic               cin;
        logic [DIGIT_W-1:0] sin;

        assign ctrl.clr      = in_beat;
        assign ctrl.conv_en  = (state_reg == S_CONV) &&
                               (cnt_reg <= CNT_W'(gi + VALUE_WIDTH - 1));
        assign ctrl.shift_en = shift;

        if (gi == 0) begin : g_first
            assign cin = val_sr_reg[VALUE_WIDTH-1];
            assign sin = '0;
        end else begin : g_rest
            assign cin = carry_w[gi-1];
            assign sin = digit_w[gi-1];
        end

        rnd_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .base      (base_reg),
            .carry_in  (cin),
            .shift_in  (sin),
            .digit     (digit_w[gi]),
            .carry_out (carry_w[gi])
        );
    end

    rnd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (emit),
        .char_in  (digit_to_ascii(top_digit)),
        .last_in  (rem_one),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // an accepted item always starts a conversion
    a_accept_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == S_CONV))
        else $error("accept did not start conversion");

    // no digit leaves before the row has settled
    a_no_early_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EMIT) |-> !emit)
        else $error("digit emitted outside emit phase");

    // the flagged digit ends the item
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && rem_one) |=> (state_reg == S_IDLE))
        else $error("last digit did not end item");

    // digit count never runs out while emitting
    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (rem_reg != '0))
        else $error("digit count exhausted in emit");

    // any value fits in DIGITS cells: the top cell never carries out
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> !carry_w[DIGITS-1])
        else $error("digit row overflow");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
    import rnd_pkg::*;

    // one emitted digit: ASCII character plus end-of-number flag
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } digit_beat_t;

    // receiver back-pressure styles, switched at random intervals
    typedef enum int {
        RDY_FREE,      // always ready, no stalls
        RDY_COIN,      // ready half the time
        RDY_SPARSE,    // ready a quarter of the time, at random
        RDY_PERIODIC   // stalls on a fixed beat pattern
    } ready_mode_t;

    localparam int unsigned RADIX_LO   = 2;
    localparam int unsigned RADIX_HI   = 16;
    localparam int unsigned DECIMAL_LO = 10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;  // 'A'
    localparam int RANDOM_NUMBERS = 320;
    localparam int REPORT_LIMIT   = 10;
    localparam int TAIL_CYCLES    = 200;  // longer than one full conversion
    localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;

    // Scoreboard: expands each accepted number into its expected digit string
    // and checks output beats in order against it.
    class digit_scoreboard;
        digit_beat_t pending_digits[$];
        int numbers_noted;
        int digits_checked;
        int mismatches;

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        // Radix conversion by repeated division; the least significant
        // digit comes out first, so build the string from the front.
        function void add_number(logic [VALUE_WIDTH-1:0] value, logic [BASE_W-1:0] base);
            int unsigned       radix;
            logic [VALUE_WIDTH-1:0] rest;
            int unsigned       d;
            digit_beat_t       beat;
            digit_beat_t       digits[$];
            radix = base;
            // out-of-range radix codes clamp to 2 and 16
            if (radix < RADIX_LO) radix = RADIX_LO;
            if (radix > RADIX_HI) radix = RADIX_HI;
            rest = value;
            do begin
                d = rest % radix;
                rest = VALUE_WIDTH'(rest / radix);
                beat.ch = (d < DECIMAL_LO) ? ASCII_ZERO + CHAR_W'(d)
                                           : ASCII_A + CHAR_W'(d - DECIMAL_LO);
                beat.is_last = 1'b0;
                digits.push_front(beat);
            end while (rest != 0);
            digits[digits.size() - 1].is_last = 1'b1;
            foreach (digits[i]) pending_digits.push_back(digits[i]);
            numbers_noted++;
        endfunction

        function void check_digit(logic [CHAR_W-1:0] ch, logic is_last);
            digit_beat_t want;
            digits_checked++;
            if (pending_digits.size() == 0) begin
                note_mismatch($sformatf("unexpected digit: char=0x%02h last=%0b", ch, is_last));
            end else begin
                want = pending_digits.pop_front();
                if (want.ch !== ch)
                    note_mismatch($sformatf("digit_char: expected 0x%02h got 0x%02h",
                                            want.ch, ch));
                if (want.is_last !== is_last)
                    note_mismatch($sformatf("last: expected %0b got %0b (char 0x%02h)",
                                            want.is_last, is_last, ch));
            end
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // value[30:0], base[35:31], zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // digit_char[6:0], zero pad
    logic                 m_tlast;

    digit_scoreboard board = new();
    logic [31:0]  radix_codes_seen;
    ready_mode_t  ready_mode;
    int           ready_span;

    radix_n_digit_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 2-unit clock period
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop; far above the slowest legal run.
    initial begin
        #2000000;
        $display("timeout: %0d digits still outstanding", board.pending());
        $display("status: fail");
        $finish;
    end

    // Receiver: stall pattern changes style at random intervals.
    initial begin
        m_tready   = 1'b0;
        ready_span = 0;
        ready_mode = RDY_FREE;
    end
    always @(negedge aclk) begin
        if (ready_span == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_span = $urandom_range(8, 80);
        end
        ready_span--;
        case (ready_mode)
            RDY_FREE:   m_tready = 1'b1;
            RDY_COIN:   m_tready = ($urandom_range(0, 1) == 1);
            RDY_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
            default:    m_tready = (ready_span % 5) != 0;
        endcase
    end

    // Output monitor: every accepted m_ beat goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_digit(m_tdata[CHAR_W-1:0], m_tlast);
    end

    // Present one number and hold it until the beat is taken.
    task automatic send_number(logic [VALUE_WIDTH-1:0] value, logic [BASE_W-1:0] base);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_W'({base, value});
        do @(posedge aclk); while (!s_tready);
        board.add_number(value, base);
        radix_codes_seen[base] = 1'b1;
    endtask

    // Sender gap; junk on tdata while valid is low.
    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = S_TDATA_W'({$urandom, $urandom});
        end
    endtask

    // Hold off the sender until the block has emitted everything owed.
    task automatic drain_digits();
        idle_sender(1);
        while (board.pending() != 0) @(negedge aclk);
    endtask

    // Mix of value shapes: full-width random, small, zero, runs of ones,
    // single bits.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1:    return VALUE_WIDTH'($urandom);
            2:       return VALUE_WIDTH'($urandom_range(0, 300));
            3:       return '0;
            4:       return ALL_ONES >> $urandom_range(0, VALUE_WIDTH - 1);
            default: return VALUE_WIDTH'(1) << $urandom_range(0, VALUE_WIDTH - 1);
        endcase
    endfunction

    // Mostly legal radices; about one in six draws any 5-bit code, which may clamp.
    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(0, 5) == 0)
            return BASE_W'($urandom_range(0, 31));
        return BASE_W'($urandom_range(RADIX_LO, RADIX_HI));
    endfunction

    initial begin
        int burst;
        int sent;
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        radix_codes_seen = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zero, widest strings, clamped radix codes, digit boundaries.
        send_number('0, 5'd2);                      // zero -> "0"
        send_number('0, 5'd16);
        send_number(ALL_ONES, 5'd2);                // 31 ones, longest string
        send_number(ALL_ONES, 5'd16);               // 7FFFFFFF
        send_number(ALL_ONES, 5'd10);
        send_number(ALL_ONES, 5'd3);
        send_number(VALUE_WIDTH'(1) << (VALUE_WIDTH - 1), 5'd2);
        send_number(31'd1, 5'd7);
        send_number(31'd15, 5'd16);                 // single 'F'
        send_number(31'd16, 5'd16);                 // "10"
        send_number(31'd10, 5'd11);                 // single 'A'
        send_number(31'd9, 5'd10);
        send_number(31'h2AAA_AAAA, 5'd4);
        send_number(31'd12345, 5'd0);               // radix 0 -> binary
        send_number(31'd12345, 5'd1);               // radix 1 -> binary
        send_number(31'd12345, 5'd17);              // clamps to hex
        send_number(ALL_ONES, 5'd31);               // clamps to hex
        send_number('0, 5'd0);
        send_number(31'h5555_5555, 5'd8);
        send_number(31'd255, 5'd15);                // "120" in base 15
        drain_digits();

        // Random part: bursts of back-to-back numbers with random gaps.
        sent = 0;
        while (sent < RANDOM_NUMBERS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                if (sent < RANDOM_NUMBERS) begin
                    send_number(pick_value(), pick_base());
                    sent++;
                end
            end
            if (sent == RANDOM_NUMBERS / 2 || $urandom_range(0, 3) == 0) begin
                if (sent == RANDOM_NUMBERS / 2) drain_digits();
            end else begin
                idle_sender($urandom_range(1, 20));
            end
        end

        idle_sender(1);
        while (board.pending() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("converted %0d numbers into %0d digit beats, %0d of 32 radix codes driven",
                 board.numbers_noted, board.digits_checked, $countones(radix_codes_seen));
        $display("mismatches: %0d", board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
